@@ sv/ssd_pkg.sv @@
// Shared types and constants for the sensor settling detector.
package ssd_pkg;

    // Default geometry
    localparam int DEF_WINDOW     = 16;
    localparam int DEF_ANGLE_BITS = 12;

    // Fixed field widths
    localparam int ANGLE_IN_W = 12;
    localparam int SETTLED_W  = 12;
    localparam int INDEX_W    = 8;
    localparam int TOL_W      = 12;
    localparam int PTS_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    // Register reset values
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(3);
    localparam logic [PTS_W-1:0] PTS_RESET = PTS_W'(64);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_WANTED = CFG_IDX_W'(1);

    // Run phase, one-hot
    typedef enum logic [3:0] {
        ST_WAIT = 4'b0001,
        ST_FILL = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } phase_t;

    // Window control from the sequencer
    typedef struct packed {
        logic clear;   // trigger: empty the running sum
        logic fill;    // sample in fill phase: shift in, add
        logic slide;   // unsettled sample: shift in, add new, drop oldest
    } win_ctl_t;

endpackage

@@ sv/sensor_settling_detector.sv @@
// Top level of the sensor settling detector: sequencer, registers, result stage.
//
//  channel | dir | transfer when          | carries
//  --------+-----+------------------------+---------------------------------------
//  s_      | in  | s_tvalid & s_tready    | tuser: mode; tdata: angle
//  m_      | out | m_tvalid & m_tready    | tdata: settled_angle, point_index; tlast
//  cfg_    | in  | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
//  One input transfer per cycle while s_tready is high; a settled result appears on m_ the cycle after
//  the settling sample. The window average is registered at the same edge as
//  each sum update (reciprocal multiply on the new sum), ready for the next sample.
//  Reset is synchronous, active low; it clears phase, sum and counts and loads the registers with their reset values.
//  s_tready drops only while a result is held and m_tready is low.
//  cfg_ready is always high.
module sensor_settling_detector
    import ssd_pkg::*;
#(
    parameter int WINDOW     = DEF_WINDOW,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample / trigger stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [11:0] angle, [15:12] zero
    input  logic [0:0]            s_tuser,    // [0] mode
    // settled points
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,    // [11:0] settled_angle, [19:12] point_index
    output logic                  m_tlast,    // last_point
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int CMP_W  = (ANGLE_BITS > TOL_W) ? ANGLE_BITS : TOL_W;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

    // configuration registers
    logic [TOL_W-1:0] tol_reg;
    logic [PTS_W-1:0] pts_wanted_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg        <= TOL_RESET;
            pts_wanted_reg <= PTS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TOLERANCE:     tol_reg        <= cfg_data;
                REG_POINTS_WANTED: pts_wanted_reg <= cfg_data[PTS_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // input decode
    logic                  accept;
    logic                  is_sample;
    logic [ANGLE_BITS-1:0] angle;

    assign accept    = s_tvalid && s_tready;
    assign is_sample = s_tuser[0];
    assign angle     = ANGLE_BITS'(s_tdata[ANGLE_IN_W-1:0]);

    // sequencer state
    phase_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PTS_W-1:0]  done_reg, done_next;

    // result register
    logic                 out_valid_reg;
    logic [SETTLED_W-1:0] out_angle_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic                 out_last_reg;

    win_ctl_t              ctl;
    logic [ANGLE_BITS-1:0] avg;
    logic [ANGLE_BITS-1:0] diff;
    logic                  in_tol;
    logic [PTS_W-1:0]      done_inc;
    logic                  hit;

    ssd_window #(
        .WINDOW     (WINDOW),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .angle   (angle),
        .avg     (avg)
    );

    // settling test against the registered average
    assign diff     = (angle >= avg) ? (angle - avg) : (avg - angle);
    assign in_tol   = CMP_W'(diff) <= CMP_W'(tol_reg);
    assign done_inc = done_reg + PTS_W'(1);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        done_next  = done_reg;
        ctl        = '0;
        hit        = 1'b0;
        if (accept) begin
            unique case (state_reg)
                ST_WAIT: begin
                    if (!is_sample) begin
                        state_next = ST_FILL;
                        fill_next  = '0;
                        ctl.clear  = 1'b1;
                    end
                end
                ST_FILL: begin
                    if (is_sample) begin
                        ctl.fill  = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                        if (fill_next == FILL_FULL) begin
                            state_next = ST_CMP;
                        end
                    end
                end
                ST_CMP: begin
                    if (is_sample) begin
                        if (in_tol) begin
                            hit        = 1'b1;
                            done_next  = done_inc;
                            fill_next  = '0;
                            state_next = (done_inc == pts_wanted_reg) ? ST_DONE : ST_WAIT;
                        end else begin
                            ctl.slide = 1'b1;
                        end
                    end
                end
                ST_DONE: ;  // everything ignored until reset
                default: state_next = ST_WAIT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT;
            fill_reg  <= '0;
            done_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // result stage: holds a point until the downstream transfer
    assign s_tready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (hit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            out_angle_reg <= SETTLED_W'(avg);
            out_index_reg <= done_reg;
            out_last_reg  <= (done_inc == pts_wanted_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_index_reg, out_angle_reg};
    assign m_tlast  = out_last_reg;

    // a fresh result only ever comes from the comparing phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_CMP))
        else $error("result raised outside comparing phase");

    // a final point leaves the block stopped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (state_reg == ST_DONE))
        else $error("last point shown but block not stopped");

    // fill count stays in range of the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> (fill_reg < FILL_FULL))
        else $error("fill phase with full window");

    // a held result blocks new input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

@@ sv/ssd_window.sv @@
// Sample window shift line, running sum and registered rounded average.
module ssd_window
    import ssd_pkg::*;
#(
    parameter int WINDOW     = DEF_WINDOW,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  win_ctl_t              ctl,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic [ANGLE_BITS-1:0] avg
);

    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SUM_W  = ANGLE_BITS + LOG_W;
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int MUL_W  = SUM_W + 1;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);
    localparam logic [SUM_W-1:0] HALF    = SUM_W'(WINDOW / 2);

    logic [ANGLE_BITS-1:0] win_reg [WINDOW];
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [SUM_W-1:0]      biased;
    logic [SUM_W+MUL_W-1:0] prod;
    logic [ANGLE_BITS-1:0] avg_reg, avg_next;

    always_comb begin
        sum_next = sum_reg;
        if (ctl.clear) begin
            sum_next = '0;
        end else if (ctl.fill) begin
            sum_next = sum_reg + SUM_W'(angle);
        end else if (ctl.slide) begin
            sum_next = sum_reg + SUM_W'(angle) - SUM_W'(win_reg[0]);
        end
    end

    // divide by WINDOW via exact reciprocal multiply
    assign biased   = sum_next + HALF;
    assign prod     = (SUM_W+MUL_W)'(biased) * (SUM_W+MUL_W)'(RECIP_C);
    assign avg_next = ANGLE_BITS'(prod >> SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            avg_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            avg_reg <= avg_next;
        end
    end

    // oldest sample at entry 0
    always_ff @(posedge aclk) begin
        if (ctl.fill || ctl.slide) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WINDOW-1] <= angle;
        end
    end

    assign avg = avg_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the sensor settling detector.
`timescale 1ns / 1ps

module tb;
    import ssd_pkg::*;

    localparam int WIN_LEN       = DEF_WINDOW;
    localparam int RANDOM_ITEMS  = 460;
    localparam int MIN_POINTS    = 16;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic MODE_TRIGGER = 1'b0;
    localparam logic MODE_SAMPLE  = 1'b1;

    // no register sits at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(8'hFF);

    typedef struct packed {
        logic [SETTLED_W-1:0] angle;
        logic [INDEX_W-1:0]   index;
        logic                 last;
    } settled_point_t;

    // Tracks phase, window and registers; queues the point each settling sample gives.
    class settling_tracker;
        logic [TOL_W-1:0]      tol;
        logic [PTS_W-1:0]      wanted;
        logic [ANGLE_IN_W-1:0] win [WIN_LEN];
        int unsigned           sum;
        phase_t                phase;
        int unsigned           fill;
        logic [INDEX_W-1:0]    done_count;
        settled_point_t        settled_queue [$];
        int unsigned           errors;

        function new();
            tol        = TOL_RESET;
            wanted     = PTS_RESET;
            sum        = 0;
            phase      = ST_WAIT;
            fill       = 0;
            done_count = '0;
            errors     = 0;
            foreach (win[i]) win[i] = '0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == REG_TOLERANCE) begin
                tol = data[TOL_W-1:0];
            end else if (idx == REG_POINTS_WANTED) begin
                wanted = data[PTS_W-1:0];
            end
        endfunction

        function logic [SETTLED_W-1:0] rounded_mean();
            return SETTLED_W'((sum + WIN_LEN / 2) / WIN_LEN);
        endfunction

        function bit ignores(input logic mode);
            if (phase == ST_DONE) return 1'b1;
            if (phase == ST_WAIT) return mode == MODE_SAMPLE;
            return mode == MODE_TRIGGER;
        endfunction

        function void take_item(input logic mode, input logic [ANGLE_IN_W-1:0] angle);
            logic [SETTLED_W-1:0] avg;
            logic [SETTLED_W-1:0] diff;
            settled_point_t       pt;
            if (ignores(mode)) return;
            case (phase)
                ST_WAIT: begin
                    phase = ST_FILL;
                    fill  = 0;
                    sum   = 0;
                end
                ST_FILL: begin
                    win[fill] = angle;
                    sum       = sum + angle;
                    fill++;
                    if (fill >= WIN_LEN) phase = ST_CMP;
                end
                default: begin
                    avg  = rounded_mean();
                    diff = (angle >= avg) ? angle - avg : avg - angle;
                    if (diff <= tol) begin
                        pt.angle   = avg;
                        pt.index   = done_count;
                        done_count = done_count + 1'b1;
                        pt.last    = (done_count == wanted);
                        phase      = pt.last ? ST_DONE : ST_WAIT;
                        fill       = 0;
                        settled_queue.push_back(pt);
                    end else begin
                        sum = sum - win[0];
                        for (int i = 0; i + 1 < WIN_LEN; i++) win[i] = win[i + 1];
                        win[WIN_LEN - 1] = angle;
                        sum = sum + angle;
                    end
                end
            endcase
        endfunction

        function void check_point(input logic [23:0] data, input logic last);
            settled_point_t want;
            if (settled_queue.size() == 0) begin
                $display("%0t: unexpected point: angle %0d index %0d last %0b",
                         $time, data[11:0], data[19:12], last);
                errors++;
                return;
            end
            want = settled_queue.pop_front();
            if (data[11:0] !== want.angle) begin
                $display("%0t: settled_angle expected %0d actual %0d",
                         $time, want.angle, data[11:0]);
                errors++;
            end
            if (data[19:12] !== want.index) begin
                $display("%0t: point_index expected %0d actual %0d",
                         $time, want.index, data[19:12]);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_point expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;    // [11:0] angle, [15:12] zero
    logic [0:0]            s_tuser   = '0;    // [0] mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;           // [11:0] settled_angle, [19:12] point_index
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    settling_tracker tracker = new();   // checks the outputs
    settling_tracker steer   = new();   // the stimulus' own view, for steering sequences

    bit          calm         = 1'b0;   // no random gaps on either side while set
    bit          hold_request = 1'b0;
    bit          hold_active  = 1'b0;
    int unsigned useful_items = 0;
    int unsigned cycles       = 0;

    sensor_settling_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL sensor_settling_detector");
            $finish;
        end
    end

    // Transfers at the edge, config first; user writes only while idle, unenforced.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) tracker.take_item(s_tuser[0], s_tdata[ANGLE_IN_W-1:0]);
            if (m_tvalid && m_tready) tracker.check_point(m_tdata, m_tlast);
        end
    end

    // Mostly no gap, some short ones, the odd long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [11:0] jitter(input logic [11:0] centre, input int unsigned spread);
        int v;
        v = int'(centre) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        return v[11:0];
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int unsigned run_len;
        int unsigned stall;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_active = 1'b0;
            end else begin
                m_tready <= 1'b1;
                run_len = $urandom_range(1, 30);
                repeat (run_len) @(posedge aclk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    // Offers one item until transferred; valid stays high unless a gap follows.
    task automatic push_item(input logic mode, input logic [11:0] angle, input int unsigned gap);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, angle};
        do @(posedge aclk); while (!s_tready);
        if (!steer.ignores(mode)) useful_items++;
        steer.take_item(mode, angle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        steer.write_reg(idx, data);
        @(posedge aclk);
    endtask

    // Sender stops until every outstanding point has come out, then lets the block settle.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.settled_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Either already passed (stops only on wrap) or out of reach of this run.
    task automatic reconfigure();
        int unsigned r;
        logic [PTS_W-1:0] pts;
        r = $urandom_range(0, 99);
        if (r < 10)      write_reg(REG_TOLERANCE, '0);
        else if (r < 20) write_reg(REG_TOLERANCE, 12'hFFF);
        else if (r < 75) write_reg(REG_TOLERANCE, CFG_DATA_W'($urandom_range(0, 15)));
        else             write_reg(REG_TOLERANCE, CFG_DATA_W'($urandom_range(0, 4095)));
        if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 3);
            if (r == 0)      pts = '1;
            else if (r == 1) pts = '0;
            else if (r == 2 && steer.done_count != '0)
                pts = PTS_W'($urandom_range(1, steer.done_count));
            else             pts = PTS_W'($urandom_range(200, 254));
            write_reg(REG_POINTS_WANTED, {4'($urandom), pts});
        end
    endtask

    // One calibration point: trigger, a full window, then compare until it settles.
    task automatic run_point(input bit keep_calm);
        logic [11:0] centre;
        logic [11:0] a;
        int unsigned spread;
        int unsigned n_far;
        int unsigned tries;
        int unsigned r;
        centre = 12'($urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        spread = (r < 40) ? $urandom_range(0, 3) : (r < 80) ? $urandom_range(4, 40) : 2047;
        n_far = $urandom_range(0, 3);
        calm = keep_calm || ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0) push_item(MODE_SAMPLE, 12'($urandom), pick_gap());
        push_item(MODE_TRIGGER, 12'($urandom), pick_gap());
        for (int i = 0; i < WIN_LEN; i++) begin
            // a stray trigger mid-fill must change nothing
            if ($urandom_range(0, 19) == 0) push_item(MODE_TRIGGER, 12'($urandom), pick_gap());
            push_item(MODE_SAMPLE, jitter(centre, spread), pick_gap());
        end
        tries = 0;
        while (steer.phase == ST_CMP) begin
            if (tries < n_far)
                a = jitter(centre ^ 12'h800, 200);
            else if (tries > n_far + 6)
                a = steer.rounded_mean();
            else
                a = jitter(steer.rounded_mean(), steer.tol + 2);
            push_item(MODE_SAMPLE, a, pick_gap());
            tries++;
        end
        calm = 1'b0;
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset registers, sample while waiting, trigger while filling,
        // extreme angles, half-up rounding, a sliding sample, a hit at the
        // tolerance boundary.
        push_item(MODE_SAMPLE, 12'hFFF, 0);
        push_item(MODE_TRIGGER, 12'hFFF, 1);
        push_item(MODE_TRIGGER, 12'h000, 0);
        for (int i = 0; i < WIN_LEN; i++)
            push_item(MODE_SAMPLE, (i % 2) ? 12'hFFF : 12'h000, pick_gap());
        push_item(MODE_SAMPLE, 12'hFFF, 0);
        push_item(MODE_SAMPLE, steer.rounded_mean() + steer.tol, 0);
        push_item(MODE_SAMPLE, 12'h555, 1);

        quiesce();
        write_reg(REG_SPARE, 12'hFFF);
        write_reg(REG_TOLERANCE, '0);
        write_reg(REG_POINTS_WANTED, 12'hFFF);
        run_point(1'b0);

        // Long hold-off downstream while points keep coming: output and input stall.
        quiesce();
        write_reg(REG_TOLERANCE, 12'hFFF);
        hold_request = 1'b1;
        while (!hold_active) @(posedge aclk);
        repeat (4) run_point(1'b1);
        quiesce();

        while (useful_items < RANDOM_ITEMS || steer.settled_queue.size() < MIN_POINTS) begin
            if ($urandom_range(0, 5) == 0) begin
                quiesce();
                reconfigure();
            end
            run_point(1'b0);
            repeat ($urandom_range(0, 2)) push_item(1'($urandom), 12'($urandom), pick_gap());
        end

        // Final point ends the run; everything after it is ignored.
        quiesce();
        write_reg(REG_TOLERANCE, CFG_DATA_W'($urandom_range(0, 8)));
        write_reg(REG_POINTS_WANTED, {4'b0, steer.done_count + 8'd1});
        run_point(1'b0);
        for (int i = 0; i < 6; i++) push_item(1'(i % 2), 12'($urandom), pick_gap());

        quiesce();
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.settled_queue.size() == 0) begin
            $display("PASS sensor_settling_detector");
        end else begin
            $display("FAIL sensor_settling_detector");
        end
        $finish;
    end

endmodule
